### rtl/core/nnue_pkg.sv
// shared types and constants for the nnue accumulator and evaluator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package nnue_pkg;
  localparam int HIDDEN_DEF = 128;
  localparam int PIECES = 6;
  localparam logic [5:0] FLIP_MASK = 6'd56;

  typedef enum logic [2:0] {
    F_LOAD_W    = 3'd0,
    F_LOAD_B    = 3'd1,
    F_LOAD_HEAD = 3'd2,
    F_RESET     = 3'd3,
    F_ADD       = 3'd4,
    F_SUB       = 3'd5,
    F_EVAL      = 3'd6,
    F_NONE      = 3'd7
  } func_t;

  localparam logic [1:0] REG_CLIP  = 2'd0;
  localparam logic [1:0] REG_QUANT = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;
  localparam logic [1:0] REG_BIAS  = 2'd3;
endpackage
`default_nettype wire

### rtl/core/nnue_if.sv
// valid/ready channel interfaces for items and results
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface nnue_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic        color;
  logic [2:0]  piece;
  logic [5:0]  square;
  logic [6:0]  neuron;
  logic signed [15:0] value;
  modport source (output valid, func, color, piece, square, neuron, value, input ready);
  modport sink (input valid, func, color, piece, square, neuron, value, output ready);
endinterface

interface nnue_out_if;
  logic        valid;
  logic        ready;
  logic        eval_valid;
  logic signed [31:0] eval;
  modport source (output valid, eval_valid, eval, input ready);
  modport sink (input valid, eval_valid, eval, output ready);
endinterface
`default_nettype wire

### rtl/core/nnue_accumulator_and_eval.sv
// two-perspective evaluator: items stream in on an input channel, one result
// per item leaves on the output channel; config via an apb-style port.
// load items (weights, biases, head weights) and ignored items pass through the load state only.
// reset/add/sub walk all HIDDEN lanes of both sides through a shared adder,
// a read step and a write step per lane and side, a pace set by the single
// read port of each memory.
// evaluate walks both sides lane by lane through one shared multiplier:
// a read step and two multiply steps per lane and side, then two divisions
// with one scale step between them.
// ready is high only while the sequencer is idle and the result register is
// empty or being taken in that cycle; a stalled receiver holds the result and
// the block accepts nothing new until the transfer.
// reset clears control state and loads register defaults; memories are
// undefined until written, no clearing pass is run.
// eval_valid is 1 only for evaluate results; eval is 0 otherwise.
`timescale 1ns / 1ps
`default_nettype none
module nnue_accumulator_and_eval
  import nnue_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  nnue_in_if.sink     in_ch,
  nnue_out_if.source  out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  localparam int HIDDEN = HIDDEN_DEF;
  localparam int LW = $clog2(HIDDEN);
  localparam int FW = 1 + 3 + 6 + LW;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LOAD  = 10'b0000000010,
    S_UPD_R = 10'b0000000100,
    S_UPD_W = 10'b0000001000,
    S_EV_RD = 10'b0000010000,
    S_EV_M1 = 10'b0000100000,
    S_EV_M2 = 10'b0001000000,
    S_DIV1  = 10'b0010000000,
    S_DIV2  = 10'b0100000000,
    S_SCALE = 10'b1000000000
  } state_t;

  state_t state;
  logic [14:0] clip_limit;
  logic [14:0] output_quant;
  logic [15:0] eval_scale;
  logic [15:0] output_bias;

  // config port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_limit <= 15'd255;
      output_quant <= 15'd64;
      eval_scale <= 16'd400;
      output_bias <= 16'd0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_CLIP:  clip_limit <= pwdata[14:0];
        REG_QUANT: output_quant <= pwdata[14:0];
        REG_SCALE: eval_scale <= pwdata[15:0];
        REG_BIAS:  output_bias <= pwdata[15:0];
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      REG_CLIP:  prdata = {17'd0, clip_limit};
      REG_QUANT: prdata = {17'd0, output_quant};
      REG_SCALE: prdata = {16'd0, eval_scale};
      REG_BIAS:  prdata = {16'd0, output_bias};
    endcase
  end

  // memories
  logic [15:0] fw_mem [2*PIECES*64*HIDDEN];
  logic [15:0] bias_mem [HIDDEN];
  logic [15:0] head_mem [2*HIDDEN];
  logic [15:0] acc_mem [2*HIDDEN];

  // latched item
  logic [2:0]  func;
  logic        color;
  logic [2:0]  piece;
  logic [5:0]  square;
  logic [6:0]  neuron;
  logic [15:0] value;

  logic        out_full;
  logic        out_eval_valid;
  logic [31:0] out_eval;
  logic        in_fire;
  assign in_ch.ready = (state == S_IDLE) && (!out_full || out_ch.ready);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_full;
  assign out_ch.eval_valid = out_eval_valid;
  assign out_ch.eval = out_eval;

  logic [LW:0] lane;
  logic        side;       // 0 own/stm side, 1 other side
  logic        lane_ok;
  logic        piece_ok;
  assign lane_ok = ({1'b0, neuron} < 8'(HIDDEN));
  assign piece_ok = (piece < 3'(PIECES));

  // address forming
  logic [5:0]  sq_sel;
  logic        half_sel;
  logic [FW-1:0] fw_rd_addr;
  logic [FW-1:0] fw_wr_addr;
  logic        acc_col;
  assign acc_col = color ^ side;
  assign half_sel = ~side;
  assign sq_sel = square ^ ((color ^ side) ? 6'd0 : FLIP_MASK);
  assign fw_rd_addr = FW'(((({9'd0, half_sel} * 10'(PIECES) + {7'd0, piece}) * 10'd64
                        + {4'd0, sq_sel}) << LW) + lane[LW-1:0]);
  assign fw_wr_addr = FW'(((({9'd0, color} * 10'(PIECES) + {7'd0, piece}) * 10'd64
                        + {4'd0, square}) << LW) + neuron[LW-1:0]);

  logic [15:0] fw_q, bias_q, head_q, acc_q;
  logic [LW:0] acc_rd_addr;
  logic [LW:0] head_rd_addr;
  assign acc_rd_addr = {acc_col, lane[LW-1:0]};
  assign head_rd_addr = {half_sel, lane[LW-1:0]};

  always_ff @(posedge clk) begin
    fw_q <= fw_mem[fw_rd_addr];
    bias_q <= bias_mem[lane[LW-1:0]];
    head_q <= head_mem[head_rd_addr];
    acc_q <= acc_mem[acc_rd_addr];
  end

  logic        fw_we, bias_we, head_we, acc_we;
  logic [15:0] acc_wd;
  always_ff @(posedge clk) begin
    if (fw_we) fw_mem[fw_wr_addr] <= value;
    if (bias_we) bias_mem[neuron[LW-1:0]] <= value;
    if (head_we) head_mem[{color, neuron[LW-1:0]}] <= value;
    if (acc_we) acc_mem[acc_rd_addr] <= acc_wd;
  end

  // shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  assign mul_p = 64'(mul_a * mul_b);

  logic signed [15:0] clamp_v;
  logic signed [15:0] acc_s;
  assign acc_s = acc_q;
  always_comb begin
    if (acc_s < 0) clamp_v = 16'sd0;
    else if (acc_s > $signed({1'b0, clip_limit})) clamp_v = $signed({1'b0, clip_limit});
    else clamp_v = acc_s;
  end

  logic signed [15:0] a_reg;
  logic signed [15:0] prod16;
  logic signed [63:0] sum;

  logic        div_start;
  logic signed [63:0] div_n;
  logic [29:0] div_d;
  logic        div_done;
  logic signed [63:0] div_q;

  nnue_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_n),
    .divisor(div_d), .done(div_done), .quotient(div_q)
  );

  logic [29:0] qa_qb;
  logic [14:0] qa1, qb1;
  assign qa1 = (clip_limit == 15'd0) ? 15'd1 : clip_limit;
  assign qb1 = (output_quant == 15'd0) ? 15'd1 : output_quant;
  assign qa_qb = 30'(qa1 * qb1);

  // biased sum fits 40 bits, scale step is a 40 by 17 multiply
  logic signed [39:0] biased;
  logic signed [56:0] scaled;
  assign scaled = biased * $signed({1'b0, eval_scale});

  always_comb begin
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    if (state == S_EV_M1) begin
      mul_a = 32'(clamp_v);
      mul_b = 32'(signed'(head_q));
    end else begin
      mul_a = 32'(prod16);
      mul_b = 32'(a_reg);
    end
  end

  logic upd_sub;
  assign upd_sub = (func == F_SUB);
  always_comb begin
    fw_we = 1'b0; bias_we = 1'b0; head_we = 1'b0; acc_we = 1'b0;
    acc_wd = upd_sub ? acc_q - fw_q : acc_q + fw_q;
    if (state == S_LOAD && lane_ok) begin
      fw_we = (func == F_LOAD_W) && piece_ok;
      bias_we = (func == F_LOAD_B);
      head_we = (func == F_LOAD_HEAD);
    end
    if (state == S_UPD_W) begin
      acc_we = 1'b1;
      if (func == F_RESET) acc_wd = bias_q;
    end
  end

  logic [LW:0] last_lane;
  assign last_lane = (LW+1)'(HIDDEN - 1);

  logic set_out;
  assign set_out = (state == S_LOAD)
                || ((state == S_UPD_W) && side && (lane == last_lane))
                || ((state == S_DIV2) && div_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= ((state == S_EV_M2) && side && (lane == last_lane))
                || (state == S_SCALE);
      out_full <= set_out || (out_full && !out_ch.ready);
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            func <= in_ch.func; color <= in_ch.color; piece <= in_ch.piece;
            square <= in_ch.square; neuron <= in_ch.neuron; value <= in_ch.value;
            lane <= '0; side <= 1'b0; sum <= '0;
            unique case (in_ch.func)
              F_RESET, F_ADD, F_SUB: begin
                if (in_ch.func == F_RESET || in_ch.piece < 3'(PIECES)) state <= S_UPD_R;
                else state <= S_LOAD;
              end
              F_EVAL: state <= S_EV_RD;
              default: state <= S_LOAD;
            endcase
          end
        end
        S_LOAD: begin
          out_eval_valid <= 1'b0; out_eval <= 32'd0;
          state <= S_IDLE;
        end
        S_UPD_R: state <= S_UPD_W;
        S_UPD_W: begin
          if (side == 1'b0 && func != F_RESET) begin
            side <= 1'b1; state <= S_UPD_R;
          end else if (side == 1'b0) begin
            side <= 1'b1; state <= S_UPD_R;
          end else if (lane == last_lane) begin
            out_eval_valid <= 1'b0; out_eval <= 32'd0;
            state <= S_IDLE;
          end else begin
            side <= 1'b0; lane <= lane + 1'b1; state <= S_UPD_R;
          end
        end
        S_EV_RD: state <= S_EV_M1;
        S_EV_M1: begin
          prod16 <= mul_p[15:0];
          a_reg <= clamp_v;
          state <= S_EV_M2;
        end
        S_EV_M2: begin
          sum <= sum + mul_p;
          if (side == 1'b0) begin
            side <= 1'b1; state <= S_EV_RD;
          end else if (lane == last_lane) begin
            div_n <= sum + mul_p; div_d <= {15'd0, qa1};
            state <= S_DIV1;
          end else begin
            side <= 1'b0; lane <= lane + 1'b1; state <= S_EV_RD;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            biased <= 40'(div_q) + 40'(signed'(output_bias));
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          div_n <= 64'(scaled); div_d <= qa_qb;
          state <= S_DIV2;
        end
        S_DIV2: begin
          if (div_done) begin
            out_eval_valid <= 1'b1;
            if (div_q > 64'sd2147483647) out_eval <= 32'h7fffffff;
            else if (div_q < -64'sd2147483648) out_eval <= 32'h80000000;
            else out_eval <= div_q[31:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/core/nnue_divider.sv
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// uses nnue_pkg only by convention of the project
`timescale 1ns / 1ps
`default_nettype none
module nnue_divider
  import nnue_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] dividend,
  input  wire logic        [29:0] divisor,
  output logic                    done,
  output logic signed [63:0]      quotient
);
  logic [63:0] rem_mag;
  logic [63:0] quo;
  logic [29:0] dvs;
  logic        neg;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;

  assign trial = {rem_mag[63:0], quo[63]} - {35'd0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt <= 7'd0;
      neg <= dividend[63];
      quo <= dividend[63] ? 64'(-dividend) : 64'(dividend);
      rem_mag <= 64'd0;
      dvs <= (divisor == 30'd0) ? 30'd1 : divisor;
    end else if (busy) begin
      if (!trial[64]) begin
        rem_mag <= trial[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem_mag <= {rem_mag[62:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
      cnt <= cnt + 7'd1;
      done <= (cnt == 7'd63);
      if (cnt == 7'd63) busy <= 1'b0;
    end else begin
      done <= 1'b0;
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);
endmodule
`default_nettype wire

### rtl/core/nnue_checker.sv
// port-level checks for the evaluator, bound to the top level
// depends on nnue_pkg and the top level ports
`timescale 1ns / 1ps
`default_nettype none
module nnue_checker
  import nnue_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_eval_valid,
  input wire logic [31:0] out_eval,
  input wire logic        pready
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_eval))
    else $error("result dropped while stalled");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_eval_valid |-> out_eval == 32'd0)
    else $error("non-eval result carries data");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted back to back");
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");
endmodule

bind nnue_accumulator_and_eval nnue_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_eval_valid(out_ch.eval_valid), .out_eval(out_ch.eval), .pready(pready)
);
`default_nettype wire
